[src/srs_pkg.sv]
// Shared types and constants of the stripe request splitter.
package srs_pkg;

    localparam int OFFSET_W    = 48;
    localparam int LENGTH_W    = 31;
    localparam int WIDTH_W     = 25;
    localparam int FILES_W     = 4;
    localparam int GSIZE_W     = 31;
    localparam int REL_W       = 30;
    localparam int BLK_W       = 6;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 2;
    localparam int DIV_CNT_W   = 6;

    localparam logic [WIDTH_W-1:0]   MAX_STRIPE_WIDTH = 25'd16777216;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WIDE   = 6'd48;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_BLK    = 6'd30;

    localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_FILES   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_BASE   = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_OUTSIDE = 2'd1,
        STATUS_EMPTY   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DD,
        ST_MUL_G,
        ST_DIV_BASE,
        ST_BASE,
        ST_LIMIT,
        ST_CHECK,
        ST_REPORT,
        ST_DIV_FD,
        ST_SAVE_FD,
        ST_DIV_BLK,
        ST_PREP_ROW,
        ST_PREP_COL,
        ST_EMIT
    } state_t;

endpackage

[src/srs_req_if.sv]
// Request channel: logical offset and length of one request.
interface srs_req_if;
    logic                           valid;
    logic                           ready;
    logic [srs_pkg::OFFSET_W-1:0]   req_offset;
    logic [srs_pkg::LENGTH_W-1:0]   req_length;

    modport source (output valid, output req_offset, output req_length, input ready);
    modport sink   (input valid, input req_offset, input req_length, output ready);
endinterface

[src/srs_piece_if.sv]
// Piece channel: one mapped piece of a request per word.
interface srs_piece_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     column;
    logic [2:0]                     row;
    logic [srs_pkg::OFFSET_W-1:0]   file_offset;
    logic [srs_pkg::WIDTH_W-1:0]    piece_length;
    srs_pkg::status_t               status;
    logic                           last;

    modport source (output valid, output column, output row, output file_offset,
                    output piece_length, output status, output last, input ready);
    modport sink   (input valid, input column, input row, input file_offset,
                    input piece_length, input status, input last, output ready);
endinterface

[src/stripe_request_splitter.sv]
// Stripe request splitter: maps a byte request onto a striped group, one word per block.
// Order: a flagged request (outside the group or empty) runs the multiplies, the base
//   division and the base, limit and check states before its report enters the output
//   register; a valid request then runs two more divisions and the row and column setup
//   before its first piece, then gives one piece per cycle while the output is taken.
// One request at a time; divisions share a shift-subtract divider (48 + 48 + 30 steps).
// Reset: configuration returns to 4096 / 4 / 0, no word held.
module stripe_request_splitter #(
    parameter int unsigned MAX_DATA_FILES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [srs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data,
    srs_req_if.sink                         req,
    srs_piece_if.source                     piece
);
    import srs_pkg::*;

    localparam logic [FILES_W-1:0] MaxFiles = FILES_W'(MAX_DATA_FILES);

    // Configuration registers
    logic [WIDTH_W-1:0]  sw_reg, sw_next;
    logic [FILES_W-1:0]  df_reg, df_next;
    logic [OFFSET_W-1:0] gb_reg, gb_next;

    // Sequencer and output word valid
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0] dv_cnt_reg, dv_cnt_next;

    // Request working registers
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [LENGTH_W-1:0] rem_reg, rem_next;
    logic [OFFSET_W:0]   end_reg, end_next;
    logic [6:0]          dd_reg, dd_next;
    logic [GSIZE_W-1:0]  gsize_reg, gsize_next;
    logic [OFFSET_W-1:0] base_reg, base_next;
    logic [OFFSET_W:0]   lim_reg, lim_next;
    logic [REL_W-1:0]    rel_reg, rel_next;
    logic [OFFSET_W-1:0] fd_reg, fd_next;
    logic [WIDTH_W-1:0]  inb_reg, inb_next;
    logic [2:0]          row_reg, row_next;
    logic [2:0]          col_reg, col_next;
    logic [OFFSET_W-1:0] rowoff_reg, rowoff_next;
    status_t             flag_reg, flag_next;

    // Shared divider: remainder, shifting dividend/quotient, divisor
    logic [GSIZE_W-1:0]  dv_rem_reg, dv_rem_next;
    logic [OFFSET_W-1:0] dv_quo_reg, dv_quo_next;
    logic [GSIZE_W-1:0]  dv_div_reg, dv_div_next;

    // Output word
    logic [2:0]          out_column_reg, out_column_next;
    logic [2:0]          out_row_reg, out_row_next;
    logic [OFFSET_W-1:0] out_foff_reg, out_foff_next;
    logic [WIDTH_W-1:0]  out_len_reg, out_len_next;
    status_t             out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    // Effective geometry: zero means one, oversize saturates
    logic [WIDTH_W-1:0] w_eff;
    logic [FILES_W-1:0] d_eff;

    assign w_eff = (sw_reg == '0) ? WIDTH_W'(1) :
                   (sw_reg > MAX_STRIPE_WIDTH) ? MAX_STRIPE_WIDTH : sw_reg;
    assign d_eff = (df_reg == '0) ? FILES_W'(1) :
                   (df_reg > MaxFiles) ? MaxFiles : df_reg;

    // One restoring divider step: shift in the next dividend bit, subtract if it fits.
    logic [GSIZE_W:0]    dv_top;
    logic [GSIZE_W:0]    dv_diff;
    logic                dv_ge;
    logic [GSIZE_W-1:0]  dv_rem_step;
    logic [OFFSET_W-1:0] dv_quo_step;

    assign dv_top      = {dv_rem_reg, dv_quo_reg[OFFSET_W-1]};
    assign dv_ge       = dv_top >= {1'b0, dv_div_reg};
    assign dv_diff     = dv_top - {1'b0, dv_div_reg};
    assign dv_rem_step = dv_ge ? dv_diff[GSIZE_W-1:0] : dv_top[GSIZE_W-1:0];
    assign dv_quo_step = {dv_quo_reg[OFFSET_W-2:0], dv_ge};

    // Block index within the group comes out of the last division.
    // Row is the number of multiples of d not above it (block < d*d, so row < d).
    logic [BLK_W-1:0] blk;
    logic [2:0]       row_calc;

    assign blk = dv_quo_reg[BLK_W-1:0];

    always_comb
    begin
        logic [6:0] cand;
        cand     = '0;
        row_calc = '0;
        for (int r = 1; r < 8; r++)
        begin
            cand = 7'(r) * {3'b000, d_eff};
            if (cand <= {1'b0, blk})
            begin
                row_calc = row_calc + 3'd1;
            end
        end
    end

    // Per-piece arithmetic: length up to the block end, file offset, column wrap.
    logic [WIDTH_W-1:0]  room;
    logic                fits;
    logic [WIDTH_W-1:0]  piece_len;
    logic [OFFSET_W-1:0] piece_foff;
    logic                col_wrap;
    logic [6:0]          row_d;
    logic [27:0]         row_w;
    logic                out_free;
    logic                outside;
    logic [OFFSET_W-1:0] rel_full;

    assign room       = w_eff - inb_reg;
    assign fits       = rem_reg <= {{(LENGTH_W-WIDTH_W){1'b0}}, room};
    assign piece_len  = fits ? rem_reg[WIDTH_W-1:0] : room;
    assign piece_foff = rowoff_reg + {{(OFFSET_W-WIDTH_W){1'b0}}, inb_reg};
    assign col_wrap   = ({1'b0, col_reg} + 4'd1) == d_eff;
    assign row_d      = {4'b0000, row_reg} * {3'b000, d_eff};
    assign row_w      = 28'(row_reg) * 28'(w_eff);
    assign out_free   = !out_valid_reg || piece.ready;
    assign outside    = (off_reg < base_reg) || (end_reg > lim_reg);
    assign rel_full   = off_reg - base_reg;

    assign req.ready = (state_reg == ST_IDLE);

    assign piece.valid        = out_valid_reg;
    assign piece.column       = out_column_reg;
    assign piece.row          = out_row_reg;
    assign piece.file_offset  = out_foff_reg;
    assign piece.piece_length = out_len_reg;
    assign piece.status       = out_status_reg;
    assign piece.last         = out_last_reg;

    // Configuration writes
    always_comb
    begin
        sw_next = sw_reg;
        df_next = df_reg;
        gb_next = gb_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STRIPE_WIDTH: sw_next = cfg_data[WIDTH_W-1:0];
                REG_DATA_FILES:   df_next = cfg_data[FILES_W-1:0];
                REG_GROUP_BASE:   gb_next = cfg_data[OFFSET_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer: next state, datapath loads and output word
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !piece.ready;
        dv_cnt_next     = dv_cnt_reg;
        off_next        = off_reg;
        rem_next        = rem_reg;
        end_next        = end_reg;
        dd_next         = dd_reg;
        gsize_next      = gsize_reg;
        base_next       = base_reg;
        lim_next        = lim_reg;
        rel_next        = rel_reg;
        fd_next         = fd_reg;
        inb_next        = inb_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        rowoff_next     = rowoff_reg;
        flag_next       = flag_reg;
        dv_rem_next     = dv_rem_reg;
        dv_quo_next     = dv_quo_reg;
        dv_div_next     = dv_div_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        out_foff_next   = out_foff_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    off_next   = req.req_offset;
                    rem_next   = req.req_length;
                    state_next = ST_MUL_DD;
                end
            end

            ST_MUL_DD:
            begin
                dd_next    = 7'({4'b0000, d_eff} * {4'b0000, d_eff});
                end_next   = {1'b0, off_reg} + {{(OFFSET_W+1-LENGTH_W){1'b0}}, rem_reg};
                state_next = ST_MUL_G;
            end

            ST_MUL_G:
            begin
                // Group size, then start group_base mod group size
                gsize_next  = GSIZE_W'(32'(dd_reg) * 32'(w_eff));
                dv_div_next = GSIZE_W'(32'(dd_reg) * 32'(w_eff));
                dv_quo_next = gb_reg;
                dv_rem_next = '0;
                dv_cnt_next = DIV_STEPS_WIDE;
                state_next  = ST_DIV_BASE;
            end

            ST_DIV_BASE:
            begin
                dv_rem_next = dv_rem_step;
                dv_quo_next = dv_quo_step;
                dv_cnt_next = dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = ST_BASE;
                end
            end

            ST_BASE:
            begin
                // Round the base down to a group boundary
                base_next  = gb_reg - {{(OFFSET_W-GSIZE_W){1'b0}}, dv_rem_reg};
                state_next = ST_LIMIT;
            end

            ST_LIMIT:
            begin
                lim_next   = {1'b0, base_reg} + {{(OFFSET_W+1-GSIZE_W){1'b0}}, gsize_reg};
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                rel_next = rel_full[REL_W-1:0];
                if (outside)
                begin
                    flag_next  = STATUS_OUTSIDE;
                    state_next = ST_REPORT;
                end
                else if (rem_reg == '0)
                begin
                    flag_next  = STATUS_EMPTY;
                    state_next = ST_REPORT;
                end
                else
                begin
                    // Start base / d: file offset of the group's first row
                    dv_quo_next = base_reg;
                    dv_div_next = GSIZE_W'(d_eff);
                    dv_rem_next = '0;
                    dv_cnt_next = DIV_STEPS_WIDE;
                    state_next  = ST_DIV_FD;
                end
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_column_next = '0;
                    out_row_next    = '0;
                    out_foff_next   = '0;
                    out_len_next    = '0;
                    out_status_next = flag_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_DIV_FD:
            begin
                dv_rem_next = dv_rem_step;
                dv_quo_next = dv_quo_step;
                dv_cnt_next = dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = ST_SAVE_FD;
                end
            end

            ST_SAVE_FD:
            begin
                // Hold base / d, start offset-in-group / stripe width (30-bit dividend)
                fd_next     = dv_quo_reg;
                dv_quo_next = {rel_reg, {(OFFSET_W-REL_W){1'b0}}};
                dv_div_next = GSIZE_W'(w_eff);
                dv_rem_next = '0;
                dv_cnt_next = DIV_STEPS_BLK;
                state_next  = ST_DIV_BLK;
            end

            ST_DIV_BLK:
            begin
                dv_rem_next = dv_rem_step;
                dv_quo_next = dv_quo_step;
                dv_cnt_next = dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = ST_PREP_ROW;
                end
            end

            ST_PREP_ROW:
            begin
                inb_next   = dv_rem_reg[WIDTH_W-1:0];
                row_next   = row_calc;
                state_next = ST_PREP_COL;
            end

            ST_PREP_COL:
            begin
                col_next    = 3'({1'b0, blk} - row_d);
                rowoff_next = fd_reg + {{(OFFSET_W-28){1'b0}}, row_w};
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                // A valid request spans at most d*d <= 64 blocks, so the
                // remaining length always runs out by the 64th piece.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_column_next = col_reg;
                    out_row_next    = row_reg;
                    out_foff_next   = piece_foff;
                    out_len_next    = piece_len;
                    out_status_next = STATUS_OK;
                    out_last_next   = fits;
                    rem_next        = rem_reg - {{(LENGTH_W-WIDTH_W){1'b0}}, piece_len};
                    inb_next        = '0;
                    if (col_wrap)
                    begin
                        col_next    = '0;
                        row_next    = row_reg + 3'd1;
                        rowoff_next = rowoff_reg + {{(OFFSET_W-WIDTH_W){1'b0}}, w_eff};
                    end
                    else
                    begin
                        col_next = col_reg + 3'd1;
                    end
                    if (fits)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dv_cnt_reg    <= '0;
            sw_reg        <= WIDTH_W'(4096);
            df_reg        <= FILES_W'(4);
            gb_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dv_cnt_reg    <= dv_cnt_next;
            sw_reg        <= sw_next;
            df_reg        <= df_next;
            gb_reg        <= gb_next;
        end
    end

    // Datapath and output word
    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        rem_reg        <= rem_next;
        end_reg        <= end_next;
        dd_reg         <= dd_next;
        gsize_reg      <= gsize_next;
        base_reg       <= base_next;
        lim_reg        <= lim_next;
        rel_reg        <= rel_next;
        fd_reg         <= fd_next;
        inb_reg        <= inb_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        rowoff_reg     <= rowoff_next;
        flag_reg       <= flag_next;
        dv_rem_reg     <= dv_rem_next;
        dv_quo_reg     <= dv_quo_next;
        dv_div_reg     <= dv_div_next;
        out_column_reg <= out_column_next;
        out_row_reg    <= out_row_next;
        out_foff_reg   <= out_foff_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

[tb/sv/testbench.sv]
// Testbench for the stripe request splitter: directed table, random phases, piece scoreboard.
`timescale 1ns / 1ps

module testbench;
    import srs_pkg::*;

    // Geometry limits of the block as instantiated (default parameters).
    localparam int unsigned FILES_MAX      = 8;
    localparam int          PIECE_LIMIT    = 64;
    localparam int          PHASES         = 6;
    localparam int          PHASE_REQUESTS = 32;
    localparam int          HOLD_CYCLES    = 400;   // long sink hold-off
    localparam int          SETTLE_CYCLES  = 300;   // request latency plus a full burst
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          REPORT_LIMIT   = 10;

    // One mapped piece as it appears on the piece channel.
    typedef struct {
        logic [2:0]          column;
        logic [2:0]          row;
        logic [OFFSET_W-1:0] file_offset;
        logic [WIDTH_W-1:0]  piece_length;
        status_t             status;
        logic                last;
    } piece_t;

    // One directed row: optional register load, then one request. Where the
    // answer is obvious it is typed in; otherwise the mapping model decides.
    typedef struct {
        bit                    reconfig;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] files;
        logic [CFG_DATA_W-1:0] base;
        logic [OFFSET_W-1:0]   offset;
        logic [LENGTH_W-1:0]   length;
        bit                    typed;
        piece_t                want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    srs_req_if   req_ch();
    srs_piece_if piece_ch();

    stripe_request_splitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .piece     (piece_ch)
    );

    // Local copy of the registers, as the block holds them (masked widths).
    logic [WIDTH_W-1:0]  cfg_width = 25'd4096;
    logic [FILES_W-1:0]  cfg_files = 4'd4;
    logic [OFFSET_W-1:0] cfg_base  = '0;

    piece_t pending_pieces[$];

    int  mismatches     = 0;
    int  n_requests     = 0;
    int  n_pieces       = 0;
    int  n_outside      = 0;
    int  n_empty        = 0;
    int  n_settings     = 0;
    int  stalled_cycles = 0;
    bit  no_idle        = 1'b0;
    bit  hold_request   = 1'b0;

    // Directed rows. Reset geometry first (4096-byte blocks, 4 files, group of
    // 64 KiB at 0), then the extremes of each register, then a tiny odd group.
    dir_row_t dir_rows [21] = '{
        // empty request at the group start
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd0, 31'd0, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_EMPTY, 1'b1}},
        // one byte at the very start
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd0, 31'd1, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd1, STATUS_OK, 1'b1}},
        // last byte of the group: last column, last row
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd65535, 31'd1, 1'b1,
          '{3'd3, 3'd3, 48'd16383, 25'd1, STATUS_OK, 1'b1}},
        // one byte past the group end
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd65535, 31'd2, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OUTSIDE, 1'b1}},
        // whole group, one piece per block
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd0, 31'd65536, 1'b0,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b0}},
        // unaligned start and end
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd100, 31'd8000, 1'b0,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b0}},
        // empty request outside the group still reports outside
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 31'd0, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OUTSIDE, 1'b1}},
        // empty request exactly at the group end is still inside
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd65536, 31'd0, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_EMPTY, 1'b1}},
        // smallest group: one-byte blocks, one file, base 0x123
        '{1'b1, 48'd1, 48'd1, 48'h123, 48'h123, 31'd1, 1'b1,
          '{3'd0, 3'd0, 48'h123, 25'd1, STATUS_OK, 1'b1}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'h122, 31'd1, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OUTSIDE, 1'b1}},
        // largest group, base unaligned at the top of the space
        '{1'b1, 48'd16777216, 48'd8, 48'hFFFF_FFFF_FFFF, 48'hFFFF_C000_0000,
          31'h4000_0000, 1'b0, '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b0}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 31'd1, 1'b1,
          '{3'd7, 3'd7, 48'h1FFF_FFFF_FFFF, 25'd1, STATUS_OK, 1'b1}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'hFFFF_BFFF_FFFF, 31'd1, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OUTSIDE, 1'b1}},
        // zero width and zero files fall back to one
        '{1'b1, 48'd0, 48'd0, 48'd5, 48'd5, 31'd1, 1'b1,
          '{3'd0, 3'd0, 48'd5, 25'd1, STATUS_OK, 1'b1}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd5, 31'd2, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OUTSIDE, 1'b1}},
        // oversize width and file count saturate
        '{1'b1, 48'h1FF_FFFF, 48'd15, 48'd0, 48'd1073741724, 31'd100, 1'b0,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b0}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd12345678, 31'd300000000, 1'b0,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b0}},
        // odd geometry, base 100 rounds down to 81
        '{1'b1, 48'd3, 48'd3, 48'd100, 48'd81, 31'd27, 1'b0,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b0}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd80, 31'd1, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OUTSIDE, 1'b1}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd90, 31'd5, 1'b0,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b0}},
        '{1'b0, 48'd0, 48'd0, 48'd0, 48'd108, 31'd0, 1'b1,
          '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_EMPTY, 1'b1}}
    };

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Effective geometry: clamp width and file count, round the base down to
    // a whole group.
    function automatic void group_geometry(output bit [63:0] w, output bit [63:0] d,
                                           output bit [63:0] g, output bit [63:0] base);
        w = 64'(cfg_width);
        if (w == 0)
            w = 1;
        else if (w > MAX_STRIPE_WIDTH)
            w = 64'(MAX_STRIPE_WIDTH);
        d = 64'(cfg_files);
        if (d == 0)
            d = 1;
        else if (d > FILES_MAX)
            d = 64'(FILES_MAX);
        g    = d * d * w;
        base = (cfg_base / g) * g;
    endfunction

    // Map one request onto the group and queue the pieces it must produce.
    function automatic void map_request(input logic [OFFSET_W-1:0] off,
                                        input logic [LENGTH_W-1:0] len);
        bit [63:0] w, d, g, base, x, remain, in_blk, room, take;
        piece_t    p;
        int        n;
        group_geometry(w, d, g, base);
        x      = 64'(off);
        remain = 64'(len);
        n      = 0;
        p      = '{3'd0, 3'd0, 48'd0, 25'd0, STATUS_OK, 1'b1};
        if (x < base || x + remain > base + g)
        begin
            p.status = STATUS_OUTSIDE;
            pending_pieces.push_back(p);
        end
        else if (remain == 0)
        begin
            p.status = STATUS_EMPTY;
            pending_pieces.push_back(p);
        end
        else
        begin
            // One piece per block touched; stop at the block edge or the request end.
            while (remain != 0 && n < PIECE_LIMIT)
            begin
                in_blk         = x % w;
                room           = w - in_blk;
                take           = (remain < room) ? remain : room;
                p.column       = 3'((x / w) % d);
                p.row          = 3'((x / (d * w)) % d);
                p.file_offset  = 48'((x / (d * w)) * w + in_blk);
                p.piece_length = 25'(take);
                remain         = remain - take;
                x              = x + take;
                p.last         = (remain == 0 || n == PIECE_LIMIT - 1);
                pending_pieces.push_back(p);
                n++;
            end
        end
    endfunction

    function automatic string piece_text(input piece_t p);
        return $sformatf("col %0d row %0d off 0x%h len %0d status %0d last %0d",
                         p.column, p.row, p.file_offset, p.piece_length, p.status, p.last);
    endfunction

    // Score one accepted word against the oldest expectation.
    task automatic check_piece();
        piece_t got;
        piece_t want;
        got = '{piece_ch.column, piece_ch.row, piece_ch.file_offset,
                piece_ch.piece_length, piece_ch.status, piece_ch.last};
        n_pieces++;
        if (got.status == STATUS_OUTSIDE)
            n_outside++;
        if (got.status == STATUS_EMPTY)
            n_empty++;
        if (pending_pieces.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected piece: %s", piece_text(got));
        end
        else
        begin
            want = pending_pieces.pop_front();
            if (got.column !== want.column || got.row !== want.row ||
                got.file_offset !== want.file_offset ||
                got.piece_length !== want.piece_length ||
                got.status !== want.status || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("piece mismatch, expected: %s", piece_text(want));
                    $display("                actual:   %s", piece_text(got));
                end
            end
        end
    endtask

    // Score every word that leaves the block.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && piece_ch.valid === 1'b1 && piece_ch.ready === 1'b1)
            check_piece();
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (piece_ch.valid === 1'b1 && piece_ch.ready === 1'b1))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", stalled_cycles);
            $display("TB_ERROR");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // Piece sink: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin : piece_sink
        int burst;
        int hold;
        burst = 0;
        hold  = 0;
        piece_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold         = HOLD_CYCLES;
            end
            if (rst_n !== 1'b1)
                piece_ch.ready <= 1'b0;
            else if (hold > 0)
            begin
                // hold off so the block fills up and stalls its input
                hold--;
                piece_ch.ready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                piece_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 7) - 1;
                piece_ch.ready <= 1'b0;
            end
            else
                piece_ch.ready <= 1'b1;
        end
    end

    // Write one register; the edge that follows commits it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_STRIPE_WIDTH: cfg_width = data[WIDTH_W-1:0];
            REG_DATA_FILES:   cfg_files = data[FILES_W-1:0];
            REG_GROUP_BASE:   cfg_base  = data[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] width,
                               input logic [CFG_DATA_W-1:0] files,
                               input logic [CFG_DATA_W-1:0] base);
        write_reg(REG_STRIPE_WIDTH, width);
        write_reg(REG_DATA_FILES, files);
        write_reg(REG_GROUP_BASE, base);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Offer one request and hold it until the block takes it. Valid stays high
    // on return so back-to-back words need no second assignment.
    task automatic offer_request(input logic [OFFSET_W-1:0] off,
                                 input logic [LENGTH_W-1:0] len);
        req_ch.valid      <= 1'b1;
        req_ch.req_offset <= off;
        req_ch.req_length <= len;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        n_requests++;
    endtask

    // Random sender gap, skipped in the last phase.
    task automatic sender_gap();
        int n;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 7);
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every queued piece has come back.
    task automatic drain_pieces();
        req_ch.valid <= 1'b0;
        while (pending_pieces.size() != 0)
            @(posedge clk);
    endtask

    // Draw one request. Most land inside the group with random size; the rest
    // are empty, just past the end, just below the base, or anywhere at all.
    task automatic pick_request(output logic [OFFSET_W-1:0] off,
                                output logic [LENGTH_W-1:0] len);
        bit [63:0]   w, d, g, base, rel, room, cap, raw;
        int unsigned kind;
        group_geometry(w, d, g, base);
        kind = $urandom_range(0, 19);
        raw  = {$urandom, $urandom};
        if (kind < 15)
        begin
            rel  = 64'($urandom_range(0, 32'(g - 1)));
            room = g - rel;
            cap  = room;
            if ($urandom_range(0, 1) == 1 && 3 * w < room)
                cap = 3 * w;
            off = 48'(base + rel);
            len = 31'($urandom_range(1, 32'(cap)));
        end
        else if (kind == 15)
        begin
            off = 48'(base + $urandom_range(0, 32'(g)));
            len = '0;
        end
        else if (kind == 16)
        begin
            rel = 64'($urandom_range(1, 32'(g)));
            off = 48'(base + rel);
            len = 31'(g - rel + 1);
        end
        else if (kind == 17)
        begin
            off = 48'(base - $urandom_range(1, 1000));
            len = 31'($urandom_range(0, 1000));
        end
        else
        begin
            off = raw[OFFSET_W-1:0];
            len = 31'($urandom_range(0, 32'h4000_0000));
        end
    endtask

    initial
    begin : stimulus
        logic [OFFSET_W-1:0]   off;
        logic [LENGTH_W-1:0]   len;
        logic [CFG_DATA_W-1:0] w_raw, d_raw, b_raw;

        // Known values on every input from time zero.
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_STRIPE_WIDTH;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_offset <= '0;
        req_ch.req_length <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: load registers where a row asks, while idle.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].reconfig)
            begin
                drain_pieces();
                load_config(dir_rows[i].width, dir_rows[i].files, dir_rows[i].base);
            end
            offer_request(dir_rows[i].offset, dir_rows[i].length);
            if (dir_rows[i].typed)
                pending_pieces.push_back(dir_rows[i].want);
            else
                map_request(dir_rows[i].offset, dir_rows[i].length);
            sender_gap();
        end

        // Random phases, each with its own register setting. Upper bits of the
        // width and file-count words carry junk the block must ignore.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_pieces();
            w_raw = CFG_DATA_W'({$urandom, $urandom});
            d_raw = CFG_DATA_W'({$urandom, $urandom});
            b_raw = CFG_DATA_W'({$urandom, $urandom});
            case (phase)
                0:
                begin
                    w_raw[WIDTH_W-1:0] = 25'($urandom_range(1, 16));
                    d_raw[FILES_W-1:0] = 4'($urandom_range(1, 8));
                    b_raw              = 48'($urandom_range(0, 1000));
                end
                1:
                begin
                    w_raw[WIDTH_W-1:0] = 25'($urandom_range(17, 5000));
                    d_raw[FILES_W-1:0] = 4'($urandom_range(0, 15));
                end
                2:
                begin
                    w_raw[WIDTH_W-1:0] = 25'($urandom_range(0, 3));
                    d_raw[FILES_W-1:0] = 4'($urandom_range(0, 15));
                end
                3:
                    d_raw[FILES_W-1:0] = 4'($urandom_range(1, 8));
                4:
                begin
                    w_raw[WIDTH_W-1:0] = 25'($urandom_range(1, 70000));
                    d_raw[FILES_W-1:0] = 4'($urandom_range(2, 8));
                end
                default:
                begin
                    // widest blocks, most files, no idling from here on
                    w_raw[WIDTH_W-1:0] = 25'h1FF_FFFF;
                    d_raw[FILES_W-1:0] = 4'd8;
                    no_idle            = 1'b1;
                end
            endcase
            load_config(w_raw, d_raw, b_raw);

            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                // long sink hold-off while requests keep coming
                if (phase == 1 && k == 8)
                    hold_request = 1'b1;
                // pause the sender until the block has emptied out
                if (phase == 2 && k == 16)
                    drain_pieces();
                pick_request(off, len);
                offer_request(off, len);
                map_request(off, len);
                sender_gap();
            end
        end

        // Drain, then watch a while longer for stray words.
        drain_pieces();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests under %0d register settings: %0d pieces scored,",
                 n_requests, n_settings, n_pieces);
        $display("  %0d outside-group and %0d empty reports, %0d mismatches.",
                 n_outside, n_empty, mismatches);
        if (mismatches == 0 && pending_pieces.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
